### rtl/waveform_peak_finder_assert.svh
// Assertion macros used by the peak finder RTL.
`ifndef WAVEFORM_PEAK_FINDER_ASSERT_SVH
`define WAVEFORM_PEAK_FINDER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WPF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("peak finder check failed");

// The consequent must hold in the cycle after the antecedent.
`define WPF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("peak finder check failed");

`endif

### rtl/wpf_pkg.sv
package wpf_pkg;

    // Tick counter range; the counter saturates at MAX_TICKS-1.
    localparam int MAX_TICKS = 4096;
    localparam int TICK_W    = $clog2(MAX_TICKS);

    // Widths of the fields on the ports.
    localparam int SAMPLE_W   = 16;
    localparam int WIRE_W     = 12;
    localparam int PLANE_W    = 3;
    localparam int OUT_TICK_W = 12;
    localparam int DEAD_W     = 12;

    // Internal tick arithmetic is wide enough for both the counter and the outputs.
    localparam int TICK_EXT_W = (TICK_W > OUT_TICK_W) ? TICK_W : OUT_TICK_W;
    localparam int SUM_W      = ((TICK_EXT_W > DEAD_W) ? TICK_EXT_W : DEAD_W) + 1;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEADTIME  = 1'd1;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       first_of_waveform;
        logic [WIRE_W-1:0]          wire_index;
        logic [PLANE_W-1:0]         plane_index;
    } wpf_item_t;

    typedef struct packed {
        logic [PLANE_W-1:0]         out_plane;
        logic [WIRE_W-1:0]          out_wire;
        logic signed [SAMPLE_W-1:0] peak_value;
        logic [OUT_TICK_W-1:0]      peak_tick;
        logic [OUT_TICK_W-1:0]      peak_width;
    } wpf_result_t;

endpackage

### rtl/wpf_in_if.sv
interface wpf_in_if;
    import wpf_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       first_of_waveform;
    logic [WIRE_W-1:0]          wire_index;
    logic [PLANE_W-1:0]         plane_index;

    modport source (
        output valid,
        output sample,
        output first_of_waveform,
        output wire_index,
        output plane_index,
        input  ready
    );

    modport sink (
        input  valid,
        input  sample,
        input  first_of_waveform,
        input  wire_index,
        input  plane_index,
        output ready
    );

endinterface

### rtl/wpf_out_if.sv
interface wpf_out_if;
    import wpf_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [PLANE_W-1:0]         out_plane;
    logic [WIRE_W-1:0]          out_wire;
    logic signed [SAMPLE_W-1:0] peak_value;
    logic [OUT_TICK_W-1:0]      peak_tick;
    logic [OUT_TICK_W-1:0]      peak_width;

    modport source (
        output valid,
        output out_plane,
        output out_wire,
        output peak_value,
        output peak_tick,
        output peak_width,
        input  ready
    );

    modport sink (
        input  valid,
        input  out_plane,
        input  out_wire,
        input  peak_value,
        input  peak_tick,
        input  peak_width,
        output ready
    );

endinterface

### rtl/wpf_peak_core.sv
module wpf_peak_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                step,
    input  wpf_pkg::wpf_item_t                  item,
    input  logic signed [wpf_pkg::SAMPLE_W-1:0] threshold,
    input  logic [wpf_pkg::DEAD_W-1:0]          deadtime,
    output logic                                emit,
    output wpf_pkg::wpf_result_t                result
);
    import wpf_pkg::*;

    localparam logic [TICK_W-1:0] TICK_LAST = TICK_W'(MAX_TICKS - 1);

    logic [TICK_W-1:0]          tick_reg, tick_next;
    logic                       in_peak_reg, in_peak_next;
    logic signed [SAMPLE_W-1:0] max_reg, max_next;
    logic [TICK_W-1:0]          max_tick_reg, max_tick_next;
    logic [TICK_W-1:0]          start_tick_reg, start_tick_next;
    logic [TICK_W-1:0]          last_center_reg, last_center_next;
    logic                       have_last_reg, have_last_next;
    logic [WIRE_W-1:0]          wire_reg, wire_next;
    logic [PLANE_W-1:0]         plane_reg, plane_next;

    logic [TICK_W-1:0]     t;
    logic                  in_peak_cur;
    logic                  have_last_cur;
    logic                  at_threshold;
    logic                  open_ok;
    logic [SUM_W-1:0]      dead_end;
    logic [TICK_W-1:0]     width_raw;
    logic [TICK_EXT_W-1:0] tick_ext;
    logic [TICK_EXT_W-1:0] width_ext;

    // A start flag restarts the waveform at tick zero before the sample is judged.
    assign t             = item.first_of_waveform ? '0 : tick_reg;
    assign in_peak_cur   = item.first_of_waveform ? 1'b0 : in_peak_reg;
    assign have_last_cur = item.first_of_waveform ? 1'b0 : have_last_reg;
    assign wire_next     = item.first_of_waveform ? item.wire_index : wire_reg;
    assign plane_next    = item.first_of_waveform ? item.plane_index : plane_reg;

    assign at_threshold = item.sample >= threshold;
    assign dead_end     = SUM_W'(last_center_reg) + SUM_W'(deadtime);
    assign open_ok      = !have_last_cur || (dead_end < SUM_W'(t));

    assign width_raw = t - start_tick_reg;
    assign tick_ext  = TICK_EXT_W'(max_tick_reg);
    assign width_ext = TICK_EXT_W'(width_raw);

    always_comb
    begin
        in_peak_next     = in_peak_cur;
        max_next         = max_reg;
        max_tick_next    = max_tick_reg;
        start_tick_next  = start_tick_reg;
        last_center_next = last_center_reg;
        have_last_next   = have_last_cur;
        emit             = 1'b0;
        if (at_threshold)
        begin
            if (!in_peak_cur)
            begin
                if (open_ok)
                begin
                    in_peak_next    = 1'b1;
                    max_next        = item.sample;
                    max_tick_next   = t;
                    start_tick_next = t;
                end
            end
            else if (item.sample > max_reg)
            begin
                max_next      = item.sample;
                max_tick_next = t;
            end
            else
            begin
                in_peak_next     = 1'b0;
                last_center_next = max_tick_reg;
                have_last_next   = 1'b1;
                emit             = 1'b1;
            end
        end
        tick_next = (t < TICK_LAST) ? t + 1'b1 : t;
    end

    assign result.out_plane  = plane_next;
    assign result.out_wire   = wire_next;
    assign result.peak_value = max_reg;
    assign result.peak_tick  = tick_ext[OUT_TICK_W-1:0];
    assign result.peak_width = width_ext[OUT_TICK_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg        <= '0;
            in_peak_reg     <= 1'b0;
            max_reg         <= '0;
            max_tick_reg    <= '0;
            start_tick_reg  <= '0;
            last_center_reg <= '0;
            have_last_reg   <= 1'b0;
            wire_reg        <= '0;
            plane_reg       <= '0;
        end
        else if (step)
        begin
            tick_reg        <= tick_next;
            in_peak_reg     <= in_peak_next;
            max_reg         <= max_next;
            max_tick_reg    <= max_tick_next;
            start_tick_reg  <= start_tick_next;
            last_center_reg <= last_center_next;
            have_last_reg   <= have_last_next;
            wire_reg        <= wire_next;
            plane_reg       <= plane_next;
        end
    end

endmodule

### rtl/waveform_peak_finder.sv
// Threshold peak finder with deadtime. Samples enter on the samples channel, one per
// clock while samples.ready is high, and every closed peak leaves on the peaks channel
// from the result register after the sample that closed it was judged in the input
// register, where the whole decision is made. Throughput is one sample per cycle;
// samples.ready drops only while a finished peak sits unclaimed in the result
// register and the input register is full. A peak still open when a new waveform
// starts is dropped. threshold and deadtime are written through cfg_we, cfg_index and
// cfg_wdata; the user must do so only while no sample is in flight (not enforced).
`include "waveform_peak_finder_assert.svh"

module waveform_peak_finder (
    input  logic                                 clk,
    input  logic                                 rst_n,
    wpf_in_if.sink                               samples,
    wpf_out_if.source                            peaks,
    input  logic                                 cfg_we,
    input  logic [wpf_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [wpf_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
    import wpf_pkg::*;

    logic signed [SAMPLE_W-1:0] threshold_reg;
    logic [DEAD_W-1:0]          deadtime_reg;

    wpf_item_t   s1_reg;
    logic        s1_valid_reg;
    wpf_result_t out_reg;
    logic        out_valid_reg, out_valid_next;

    logic        advance;
    logic        core_emit;
    wpf_result_t core_result;
    wpf_item_t   in_item;

    assign in_item.sample            = samples.sample;
    assign in_item.first_of_waveform = samples.first_of_waveform;
    assign in_item.wire_index        = samples.wire_index;
    assign in_item.plane_index       = samples.plane_index;

    // The registered sample is processed once the result register has room for it.
    assign advance       = s1_valid_reg && (!out_valid_reg || peaks.ready);
    assign samples.ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= '0;
            deadtime_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_THRESHOLD: threshold_reg <= cfg_wdata;
                REG_DEADTIME:  deadtime_reg  <= cfg_wdata[DEAD_W-1:0];
                default:       ;
            endcase
        end
    end

    wpf_peak_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .item      (s1_reg),
        .threshold (threshold_reg),
        .deadtime  (deadtime_reg),
        .emit      (core_emit),
        .result    (core_result)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = core_emit;
        end
        else if (peaks.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (samples.ready)
            begin
                s1_valid_reg <= samples.valid;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (samples.valid && samples.ready)
        begin
            s1_reg <= in_item;
        end
        if (advance && core_emit)
        begin
            out_reg <= core_result;
        end
    end

    assign peaks.valid      = out_valid_reg;
    assign peaks.out_plane  = out_reg.out_plane;
    assign peaks.out_wire   = out_reg.out_wire;
    assign peaks.peak_value = out_reg.peak_value;
    assign peaks.peak_tick  = out_reg.peak_tick;
    assign peaks.peak_width = out_reg.peak_width;

    // A sample waiting on a stalled result stays put and is not lost.
    `WPF_ASSERT_NEXT(a_s1_hold, clk, rst_n, s1_valid_reg && !advance, s1_valid_reg && $stable(s1_reg))
    // Whenever the result side can move, the block takes a new sample.
    `WPF_ASSERT_SAME(a_no_bubble, clk, rst_n, !out_valid_reg || peaks.ready, samples.ready)
    // A processed sample that closes a peak always shows up as a valid result.
    `WPF_ASSERT_NEXT(a_emit_lands, clk, rst_n, advance && core_emit, out_valid_reg)

endmodule

### tb/sv/tb_top.sv
module tb_top;
    import wpf_pkg::*;

    localparam int RANDOM_ITEMS = 1050;

    typedef enum logic [1:0] {ROW_CFG, ROW_PRED, ROW_NONE, ROW_RES} row_kind_e;

    // Directed stimulus row. For ROW_CFG, sample carries the threshold and wire_no the
    // deadtime. For ROW_RES, typed holds the peak expected from that sample.
    typedef struct packed {
        row_kind_e         kind;
        logic signed [15:0] sample;
        logic              start;
        logic [11:0]       wire_no;
        logic [2:0]        plane_no;
        wpf_result_t       typed;
    } row_t;

    localparam int DIRECTED_ROWS = 28;

    localparam row_t DIRECTED [0:DIRECTED_ROWS-1] = '{
        // Reset settings, no start flag yet: wire and plane read as zero.
        '{ROW_NONE, 16'sd5,      1'b0, 12'd77,    3'd3, '0},
        '{ROW_NONE, 16'sd9,      1'b0, 12'd77,    3'd3, '0},
        '{ROW_RES,  16'sd9,      1'b0, 12'd77,    3'd3,
          '{3'd0, 12'd0, 16'sd9, 12'd1, 12'd2}},
        '{ROW_NONE, -16'sd1,     1'b0, 12'd0,     3'd0, '0},
        // A below-threshold sample inside a peak leaves it open.
        '{ROW_NONE, 16'sd4,      1'b1, 12'd4095,  3'd7, '0},
        '{ROW_NONE, 16'sh7fff,   1'b0, 12'd0,     3'd0, '0},
        '{ROW_NONE, 16'sh8000,   1'b0, 12'd0,     3'd0, '0},
        '{ROW_RES,  16'sh7fff,   1'b0, 12'd0,     3'd0,
          '{3'd7, 12'd4095, 16'sh7fff, 12'd1, 12'd3}},
        // A new waveform drops the peak that this sample opens.
        '{ROW_NONE, 16'sd3,      1'b0, 12'd0,     3'd0, '0},
        '{ROW_NONE, 16'sd0,      1'b1, 12'h555,   3'd5, '0},
        '{ROW_RES,  16'sd0,      1'b0, 12'd0,     3'd0,
          '{3'd5, 12'h555, 16'sd0, 12'd0, 12'd1}},
        '{ROW_CFG,  16'sh7fff,   1'b0, 12'd4095,  3'd0, '0},
        '{ROW_NONE, 16'sh7fff,   1'b1, 12'haaa,   3'd2, '0},
        '{ROW_RES,  16'sh7fff,   1'b0, 12'd0,     3'd0,
          '{3'd2, 12'haaa, 16'sh7fff, 12'd0, 12'd1}},
        // Held off by the full deadtime, then below threshold.
        '{ROW_NONE, 16'sh7fff,   1'b0, 12'd0,     3'd0, '0},
        '{ROW_NONE, 16'sh7ffe,   1'b0, 12'd0,     3'd0, '0},
        '{ROW_CFG,  16'sh8000,   1'b0, 12'd0,     3'd0, '0},
        '{ROW_NONE, 16'sh8000,   1'b1, 12'd1,     3'd1, '0},
        '{ROW_RES,  16'sh8000,   1'b0, 12'd0,     3'd0,
          '{3'd1, 12'd1, 16'sh8000, 12'd0, 12'd1}},
        '{ROW_CFG,  16'sd100,    1'b0, 12'd3,     3'd0, '0},
        '{ROW_PRED, 16'sd200,    1'b1, 12'd9,     3'd4, '0},
        '{ROW_PRED, 16'sd150,    1'b0, 12'd0,     3'd0, '0},
        '{ROW_PRED, 16'sd300,    1'b0, 12'd0,     3'd0, '0},
        '{ROW_PRED, 16'sd300,    1'b0, 12'd0,     3'd0, '0},
        '{ROW_PRED, 16'sd300,    1'b0, 12'd0,     3'd0, '0},
        '{ROW_PRED, 16'sd50,     1'b0, 12'd0,     3'd0, '0},
        '{ROW_PRED, 16'sd400,    1'b0, 12'd0,     3'd0, '0},
        '{ROW_PRED, 16'sd399,    1'b0, 12'd0,     3'd0, '0}
    };

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    wpf_in_if  samples_ch ();
    wpf_out_if peaks_ch ();

    waveform_peak_finder uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (samples_ch),
        .peaks     (peaks_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Settings as last written, and the peak tracking state of the predictor.
    logic signed [15:0] threshold_setting = '0;
    logic [11:0]        deadtime_setting  = '0;
    int                 tick_now    = 0;
    bit                 peak_open   = 1'b0;
    logic signed [15:0] peak_max    = '0;
    int                 max_at      = 0;
    int                 open_at     = 0;
    int                 last_centre = 0;
    bit                 have_centre = 1'b0;
    logic [11:0]        cur_wire    = '0;
    logic [2:0]         cur_plane   = '0;

    wpf_result_t pending_peaks[$];
    wpf_result_t want_peak;
    int          error_count  = 0;
    int unsigned src_idle_pct = 26;
    int unsigned snk_idle_pct = 56;

    function automatic bit predict_peak(input wpf_item_t it, output wpf_result_t res);
        bit closed;
        closed = 1'b0;
        res = '0;
        if (it.first_of_waveform)
        begin
            tick_now    = 0;
            peak_open   = 1'b0;
            have_centre = 1'b0;
            cur_wire    = it.wire_index;
            cur_plane   = it.plane_index;
        end
        if (it.sample >= threshold_setting)
        begin
            if (!peak_open)
            begin
                if (!have_centre || last_centre + int'(deadtime_setting) < tick_now)
                begin
                    peak_open = 1'b1;
                    peak_max  = it.sample;
                    max_at    = tick_now;
                    open_at   = tick_now;
                end
            end
            else if (it.sample > peak_max)
            begin
                peak_max = it.sample;
                max_at   = tick_now;
            end
            else
            begin
                peak_open      = 1'b0;
                res.out_plane  = cur_plane;
                res.out_wire   = cur_wire;
                res.peak_value = peak_max;
                res.peak_tick  = OUT_TICK_W'(max_at);
                res.peak_width = OUT_TICK_W'(tick_now - open_at);
                last_centre    = max_at;
                have_centre    = 1'b1;
                closed         = 1'b1;
            end
        end
        // The tick counter saturates, so late samples share the last tick.
        if (tick_now < MAX_TICKS - 1)
            tick_now++;
        return closed;
    endfunction

    // Random walk around the threshold: mostly small steps, with drops below it,
    // repeated levels that close peaks, and the odd full-range sample.
    function automatic int next_level(input int prev, input int base);
        int r;
        int v;
        v = prev;
        r = $urandom_range(0, 99);
        if (r < 8)
            v = int'($signed(16'($urandom)));
        else if (r < 18)
            v = base - int'($urandom_range(1, 300));
        else if (r >= 28)
            v = v + int'($urandom_range(0, 400)) - 170;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v;
    endfunction

    task automatic check_field(input string field_name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, field_name, want, got);
            error_count++;
        end
    endtask

    task automatic expect_peak(input wpf_result_t p);
        pending_peaks = {pending_peaks, p};
    endtask

    task automatic push_sample(input wpf_item_t it, input row_kind_e kind,
                               input wpf_result_t typed);
        wpf_result_t res;
        bit          hit;
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            samples_ch.valid <= 1'b0;
            @(posedge clk);
        end
        samples_ch.valid             <= 1'b1;
        samples_ch.sample            <= it.sample;
        samples_ch.first_of_waveform <= it.first_of_waveform;
        samples_ch.wire_index        <= it.wire_index;
        samples_ch.plane_index       <= it.plane_index;
        do
            @(posedge clk);
        while (!samples_ch.ready);
        hit = predict_peak(it, res);
        if (kind == ROW_PRED && hit)
            expect_peak(res);
        else if (kind == ROW_RES)
            expect_peak(typed);
    endtask

    // Registers change only with nothing in flight; the extra cycles cover a sample
    // that is still in the pipeline without producing a peak.
    task automatic set_config(input logic signed [15:0] thr, input logic [11:0] dead);
        samples_ch.valid <= 1'b0;
        while (pending_peaks.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_THRESHOLD;
        cfg_wdata <= CFG_DATA_W'(thr);
        @(posedge clk);
        cfg_index <= REG_DEADTIME;
        cfg_wdata <= CFG_DATA_W'(dead);
        @(posedge clk);
        cfg_we <= 1'b0;
        threshold_setting = thr;
        deadtime_setting  = dead;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20000000;
        $display("Simulation FAILED");
        $finish;
    end

    // Peak receiver and checker.
    initial
    begin
        peaks_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && peaks_ch.valid && peaks_ch.ready)
            begin
                if (pending_peaks.size() == 0)
                begin
                    $display("%0t: unexpected peak, plane %0d wire %0d value %0d tick %0d",
                             $time, peaks_ch.out_plane, peaks_ch.out_wire,
                             peaks_ch.peak_value, peaks_ch.peak_tick);
                    error_count++;
                end
                else
                begin
                    want_peak = pending_peaks.pop_front();
                    check_field("out_plane", want_peak.out_plane, peaks_ch.out_plane);
                    check_field("out_wire", want_peak.out_wire, peaks_ch.out_wire);
                    check_field("peak_value", want_peak.peak_value, peaks_ch.peak_value);
                    check_field("peak_tick", want_peak.peak_tick, peaks_ch.peak_tick);
                    check_field("peak_width", want_peak.peak_width, peaks_ch.peak_width);
                end
            end
            peaks_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    initial
    begin
        wpf_item_t          it;
        logic signed [15:0] thr;
        logic [11:0]        dead;
        int                 done_items;
        int                 seg_left;
        int                 wave_len;
        int                 level;

        rst_n                        = 1'b0;
        cfg_we                       = 1'b0;
        cfg_index                    = '0;
        cfg_wdata                    = '0;
        samples_ch.valid             = 1'b0;
        samples_ch.sample            = '0;
        samples_ch.first_of_waveform = 1'b0;
        samples_ch.wire_index        = '0;
        samples_ch.plane_index       = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            if (DIRECTED[i].kind == ROW_CFG)
                set_config(DIRECTED[i].sample, DIRECTED[i].wire_no);
            else
            begin
                it.sample            = DIRECTED[i].sample;
                it.first_of_waveform = DIRECTED[i].start;
                it.wire_index        = DIRECTED[i].wire_no;
                it.plane_index       = DIRECTED[i].plane_no;
                push_sample(it, DIRECTED[i].kind, DIRECTED[i].typed);
            end
        end

        done_items = 0;
        seg_left   = 0;
        while (done_items < RANDOM_ITEMS)
        begin
            if (done_items >= 2 * RANDOM_ITEMS / 3)
            begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            else if (done_items >= RANDOM_ITEMS / 3)
            begin
                src_idle_pct = 56;
                snk_idle_pct = 26;
            end
            if (seg_left <= 0)
            begin
                case ($urandom_range(0, 9))
                    0:       thr = 16'sh8000;
                    1:       thr = 16'sh7fff;
                    default: thr = 16'(int'($urandom_range(0, 4000)) - 2000);
                endcase
                case ($urandom_range(0, 9))
                    0:       dead = 12'd0;
                    1:       dead = 12'd4095;
                    default: dead = 12'($urandom_range(0, 24));
                endcase
                set_config(thr, dead);
                seg_left = $urandom_range(100, 180);
            end
            // Mostly proper waveforms; some lack the start flag or restart mid-way.
            wave_len = $urandom_range(2, 48);
            level    = int'(threshold_setting) - int'($urandom_range(1, 300));
            for (int k = 0; k < wave_len; k++)
            begin
                level                = next_level(level, int'(threshold_setting));
                it.sample            = 16'(level);
                it.first_of_waveform = (k == 0) ? ($urandom_range(0, 9) != 0)
                                                : ($urandom_range(0, 99) == 0);
                it.wire_index        = 12'($urandom);
                it.plane_index       = 3'($urandom);
                push_sample(it, ROW_PRED, '0);
            end
            done_items += wave_len;
            seg_left   -= wave_len;
        end

        samples_ch.valid <= 1'b0;
        while (pending_peaks.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/wpf_pkg.sv
rtl/wpf_in_if.sv
rtl/wpf_out_if.sv
rtl/wpf_peak_core.sv
rtl/waveform_peak_finder.sv
tb/sv/tb_top.sv
